@@ rtl/wvm_pkg.sv @@
`timescale 1ns / 1ps
package wvm_pkg;

  localparam int VOICE_COUNT_DEF = 15;
  localparam int WAVE_LEN_DEF    = 1024;

  // field widths
  localparam int OPC_W  = 3;
  localparam int KEY_W  = 7;
  localparam int VEL_W  = 7;
  localparam int CHAN_W = 4;
  localparam int WIDX_W = 10;
  localparam int WAVE_W = 16;
  localparam int STEP_W = 26;
  localparam int DAC_W  = 12;

  // wide enough for any supported table length
  localparam int WIDX_EXT_W = 13;
  localparam int STEP_DEPTH = 128;
  localparam int FRAC_W     = 16;

  localparam int VOL_SHIFT = 4;
  localparam int MIX_SHIFT = 10;
  localparam int DAC_MID   = 2048;
  localparam int DAC_MAX   = 4095;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK      = 3'd0,
    OP_NOTE_ON   = 3'd1,
    OP_NOTE_OFF  = 3'd2,
    OP_LOAD_WAVE = 3'd3,
    OP_LOAD_STEP = 3'd4
  } opcode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } phu_stat_t;

endpackage

@@ rtl/wvm_ifs.sv @@
`timescale 1ns / 1ps
interface wvm_in_if;
  logic                               valid;
  logic                               ready;
  logic [wvm_pkg::OPC_W-1:0]          opcode;
  logic [wvm_pkg::KEY_W-1:0]          note_key;
  logic [wvm_pkg::VEL_W-1:0]          velocity;
  logic [wvm_pkg::CHAN_W-1:0]         channel;
  logic [wvm_pkg::WIDX_W-1:0]         wave_index;
  logic signed [wvm_pkg::WAVE_W-1:0]  wave_value;
  logic [wvm_pkg::STEP_W-1:0]         step_value;

  modport source (output valid, opcode, note_key, velocity, channel, wave_index,
                  wave_value, step_value, input ready);
  modport sink (input valid, opcode, note_key, velocity, channel, wave_index,
                wave_value, step_value, output ready);
endinterface

interface wvm_out_if;
  logic                       valid;
  logic                       ready;
  logic [wvm_pkg::DAC_W-1:0]  dac_sample;

  modport source (output valid, dac_sample, input ready);
  modport sink (input valid, dac_sample, output ready);
endinterface

@@ rtl/wvm_phase_wrap.sv @@
`timescale 1ns / 1ps
// Phase advance and wrap: one add with a single wrap, then a restoring
// remainder (one shifted span per cycle) when the step was oversized.
module wvm_phase_wrap #(
  parameter int WAVE_LEN = wvm_pkg::WAVE_LEN_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [$clog2(WAVE_LEN)+wvm_pkg::FRAC_W-1:0]   phase_i,
  input  logic [wvm_pkg::STEP_W-1:0]                    inc_i,
  output wvm_pkg::phu_stat_t                            stat_o,
  output logic [$clog2(WAVE_LEN)+wvm_pkg::FRAC_W-1:0]   phase_o
);

  localparam int IDX_W = $clog2(WAVE_LEN);
  localparam int PW    = IDX_W + wvm_pkg::FRAC_W;
  localparam int SUM_W = ((PW > wvm_pkg::STEP_W) ? PW : wvm_pkg::STEP_W) + 1;
  localparam int EXT_W = SUM_W + 1;
  localparam int K     = SUM_W - PW;
  localparam int K_W   = $clog2(K + 1);
  localparam logic [EXT_W-1:0] SPAN = EXT_W'(WAVE_LEN) << wvm_pkg::FRAC_W;

  typedef enum logic {U_IDLE, U_RED} ustate_t;

  ustate_t            state_r, state_nxt;
  logic               done_r, done_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   first;
  logic [EXT_W-1:0]   span_sh;

  assign sum     = SUM_W'(phase_i) + SUM_W'(inc_i);
  assign first   = (EXT_W'(sum) >= SPAN) ? SUM_W'(EXT_W'(sum) - SPAN) : sum;
  assign span_sh = SPAN << k_r;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    case (state_r)
      U_IDLE: begin
        if (start) begin
          acc_nxt = first;
          if (EXT_W'(first) >= SPAN) begin
            k_nxt     = K_W'(K);
            state_nxt = U_RED;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
      U_RED: begin
        if (EXT_W'(acc_r) >= span_sh) begin
          acc_nxt = SUM_W'(EXT_W'(acc_r) - span_sh);
        end
        if (k_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end else begin
          k_nxt = k_r - K_W'(1);
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r <= acc_nxt;
    k_r   <= k_nxt;
  end

  assign stat_o.busy = (state_r == U_RED);
  assign stat_o.done = done_r;
  assign phase_o     = acc_r[PW-1:0];

endmodule

@@ rtl/wavetable_voice_mixer.sv @@
`timescale 1ns / 1ps
// From acceptance until ready again:
// Tick: every voice is visited; each active voice is read, advanced through
//   the phase unit (with a remainder pass when a step wraps more than once),
//   sampled and accumulated; the result then waits for the output register.
// Note on scans for a free voice; note off scans for an active matching key.
// Table loads may follow back to back.
// Reset: sync active-low; clears every voice's active bit; wave/step tables
//   hold no reset and must be written before they are read.
module wavetable_voice_mixer #(
  parameter int VOICE_COUNT = wvm_pkg::VOICE_COUNT_DEF,
  parameter int WAVE_LEN    = wvm_pkg::WAVE_LEN_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wvm_in_if.sink    in_if,
  wvm_out_if.source out_if
);

  localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int IDX_W  = $clog2(WAVE_LEN);
  localparam int LEN_W  = IDX_W + 1;
  localparam int PW     = IDX_W + wvm_pkg::FRAC_W;
  localparam int PROD_W = wvm_pkg::WAVE_W + wvm_pkg::VEL_W + 1;
  localparam int ACC_W  = PROD_W - wvm_pkg::VOL_SHIFT + CNT_W;

  // per-voice record, one memory word
  typedef struct packed {
    logic [PW-1:0]                 phase;
    logic [wvm_pkg::STEP_W-1:0]    inc;
    logic [wvm_pkg::VEL_W-1:0]     vol;
    logic [wvm_pkg::CHAN_W-1:0]    chan;
    logic [wvm_pkg::KEY_W-1:0]     note;
  } voice_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ON_SCAN,
    S_ON_WR,
    S_OFF_SCAN,
    S_OFF_CMP,
    S_TK_SCAN,
    S_TK_ADD,
    S_TK_WAIT,
    S_TK_MAC,
    S_TK_ACC,
    S_TK_FIN
  } state_t;

  // sequencer and datapath registers
  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [wvm_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [wvm_pkg::VEL_W-1:0]       vel_r, vel_nxt;
  logic [wvm_pkg::CHAN_W-1:0]      chan_r, chan_nxt;
  logic [VOICE_COUNT-1:0]          active_r, active_nxt;
  logic signed [ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [PROD_W-1:0]        prod_r, prod_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [wvm_pkg::DAC_W-1:0]       out_sample_r, out_sample_nxt;

  // memories and their registered read data
  voice_t                          vmem [VOICE_COUNT];
  voice_t                          vword_r;
  logic signed [wvm_pkg::WAVE_W-1:0] wave_mem [WAVE_LEN];
  logic signed [wvm_pkg::WAVE_W-1:0] wave_rd_r;
  logic [wvm_pkg::STEP_W-1:0]      step_mem [wvm_pkg::STEP_DEPTH];
  logic [wvm_pkg::STEP_W-1:0]      step_rd_r;

  logic                            vm_re, vm_we;
  voice_t                          vm_wdata;
  logic                            wv_we, wv_re;
  logic                            st_we, st_re;

  logic                            in_accept;
  logic [VIDX_W-1:0]               vidx;
  logic                            scan_end;
  logic [wvm_pkg::WIDX_EXT_W-1:0]  widx_ext;
  logic                            wave_in_range;
  logic [IDX_W-1:0]                wv_waddr;
  logic [IDX_W-1:0]                wv_raddr;
  logic signed [ACC_W-1:0]         mix;
  logic signed [ACC_W-1:0]         tot;
  logic [wvm_pkg::DAC_W-1:0]       clamped;

  // shared phase unit
  logic                            phu_start;
  wvm_pkg::phu_stat_t              phu_stat;
  logic [PW-1:0]                   phu_phase;

  wvm_phase_wrap #(
    .WAVE_LEN (WAVE_LEN)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (phu_start),
    .phase_i (vword_r.phase),
    .inc_i   (vword_r.inc),
    .stat_o  (phu_stat),
    .phase_o (phu_phase)
  );

  assign in_accept     = in_if.valid && in_if.ready;
  assign in_if.ready   = (state_r == S_IDLE);
  assign vidx          = cnt_r[VIDX_W-1:0];
  assign scan_end      = (cnt_r == CNT_W'(VOICE_COUNT));
  assign widx_ext      = wvm_pkg::WIDX_EXT_W'(in_if.wave_index);
  assign wave_in_range = (widx_ext < wvm_pkg::WIDX_EXT_W'(WAVE_LEN));
  assign wv_waddr      = widx_ext[IDX_W-1:0];
  assign wv_raddr      = phu_phase[PW-1:wvm_pkg::FRAC_W];

  // final mix: floor divide, recenter, clamp to the DAC range
  assign mix = acc_r >>> wvm_pkg::MIX_SHIFT;
  assign tot = mix + ACC_W'(wvm_pkg::DAC_MID);

  always_comb begin
    if (tot[ACC_W-1]) begin
      clamped = '0;
    end else if (|tot[ACC_W-2:wvm_pkg::DAC_W]) begin
      clamped = wvm_pkg::DAC_W'(wvm_pkg::DAC_MAX);
    end else begin
      clamped = tot[wvm_pkg::DAC_W-1:0];
    end
  end

  // sequencer: one voice visited per scan step
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    vel_nxt        = vel_r;
    chan_nxt       = chan_r;
    active_nxt     = active_r;
    acc_nxt        = acc_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    vm_re          = 1'b0;
    vm_we          = 1'b0;
    vm_wdata       = vword_r;
    wv_we          = 1'b0;
    wv_re          = 1'b0;
    st_we          = 1'b0;
    st_re          = 1'b0;
    phu_start      = 1'b0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          key_nxt  = in_if.note_key;
          vel_nxt  = in_if.velocity;
          chan_nxt = in_if.channel;
          cnt_nxt  = '0;
          case (in_if.opcode)
            wvm_pkg::OP_TICK: begin
              acc_nxt   = '0;
              state_nxt = S_TK_SCAN;
            end
            wvm_pkg::OP_NOTE_ON: begin
              st_re = 1'b1;
              // zero velocity is a note off
              state_nxt = (in_if.velocity == '0) ? S_OFF_SCAN : S_ON_SCAN;
            end
            wvm_pkg::OP_NOTE_OFF: state_nxt = S_OFF_SCAN;
            wvm_pkg::OP_LOAD_WAVE: wv_we = wave_in_range;
            wvm_pkg::OP_LOAD_STEP: st_we = 1'b1;
            default: ;
          endcase
        end
      end

      // first free voice; none free drops the note
      S_ON_SCAN: begin
        if (scan_end) begin
          state_nxt = S_IDLE;
        end else if (!active_r[vidx]) begin
          state_nxt = S_ON_WR;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_ON_WR: begin
        vm_we          = 1'b1;
        vm_wdata.phase = '0;
        vm_wdata.inc   = step_rd_r;
        vm_wdata.vol   = vel_r;
        vm_wdata.chan  = chan_r;
        vm_wdata.note  = key_r;
        active_nxt[vidx] = 1'b1;
        state_nxt      = S_IDLE;
      end

      // first active voice with a matching key
      S_OFF_SCAN: begin
        if (scan_end) begin
          state_nxt = S_IDLE;
        end else if (active_r[vidx]) begin
          vm_re     = 1'b1;
          state_nxt = S_OFF_CMP;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_OFF_CMP: begin
        if (vword_r.note == key_r) begin
          vm_we            = 1'b1;
          vm_wdata.chan    = '0;
          active_nxt[vidx] = 1'b0;
          state_nxt        = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_OFF_SCAN;
        end
      end

      S_TK_SCAN: begin
        if (scan_end) begin
          state_nxt = S_TK_FIN;
        end else if (active_r[vidx]) begin
          vm_re     = 1'b1;
          state_nxt = S_TK_ADD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      S_TK_ADD: begin
        phu_start = 1'b1;
        state_nxt = S_TK_WAIT;
      end

      // wrapped phase ready: write it back, fetch the wave sample
      S_TK_WAIT: begin
        if (phu_stat.done) begin
          wv_re          = 1'b1;
          vm_we          = 1'b1;
          vm_wdata.phase = phu_phase;
          state_nxt      = S_TK_MAC;
        end
      end

      S_TK_MAC: begin
        prod_nxt  = $signed(wave_rd_r) * $signed({1'b0, vword_r.vol});
        state_nxt = S_TK_ACC;
      end

      S_TK_ACC: begin
        acc_nxt   = acc_r + ACC_W'(prod_r >>> wvm_pkg::VOL_SHIFT);
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_TK_SCAN;
      end

      // wait for the output register to free up
      S_TK_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = clamped;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    vel_r        <= vel_nxt;
    chan_r       <= chan_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // voice record store
  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vidx] <= vm_wdata;
    end
    if (vm_re) begin
      vword_r <= vmem[vidx];
    end
  end

  // wave table
  always_ff @(posedge clk) begin
    if (wv_we) begin
      wave_mem[wv_waddr] <= in_if.wave_value;
    end
    if (wv_re) begin
      wave_rd_r <= wave_mem[wv_raddr];
    end
  end

  // step table, read at note-on acceptance
  always_ff @(posedge clk) begin
    if (st_we) begin
      step_mem[in_if.note_key] <= in_if.step_value;
    end
    if (st_re) begin
      step_rd_r <= step_mem[in_if.note_key];
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.dac_sample = out_sample_r;

  // a result only leaves from the final mix step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_TK_FIN)
    else $error("output valid rose outside the final mix step");

  // the shared phase unit is never restarted mid-reduction
  a_phu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phu_start |-> !phu_stat.busy)
    else $error("phase unit started while busy");

  // a phase written back always indexes inside the wave table
  a_phase_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_we && state_r == S_TK_WAIT) |->
      LEN_W'(vm_wdata.phase[PW-1:wvm_pkg::FRAC_W]) < LEN_W'(WAVE_LEN))
    else $error("wrapped phase outside the wave table");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for wavetable_voice_mixer.
// Random commands go through the input channel. Each accepted command also
// updates a local copy of the voice pool and tables. Every tick predicts one
// DAC sample, which the result checker compares in order.
module tb_top;
  import wvm_pkg::*;

  localparam int VOICES    = VOICE_COUNT_DEF;
  localparam int TBL_LEN   = WAVE_LEN_DEF;
  localparam int SPAN      = TBL_LEN << FRAC_W;  // phase wraps here
  localparam int IDLE_PCT  = 25;
  localparam int RAND_ITEMS = 150;
  localparam int STALL_LIMIT = 4000;             // cycles with no transaction at all
  localparam int TAIL_CYCLES = 200;              // idle wait at the end for stray samples

  typedef struct packed {
    logic [OPC_W-1:0]         opc;
    logic [KEY_W-1:0]         key;
    logic [VEL_W-1:0]         vel;
    logic [CHAN_W-1:0]        chan;
    logic [WIDX_W-1:0]        widx;
    logic signed [WAVE_W-1:0] wval;
    logic [STEP_W-1:0]        step;
  } synth_cmd_t;

  logic clk;
  logic rst_n;

  wvm_in_if  in_ch ();
  wvm_out_if out_ch ();

  wavetable_voice_mixer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the synthesizer state
  // ---------------------------------------------------------------------------
  logic                     v_active [VOICES];
  logic [KEY_W-1:0]         v_note   [VOICES];
  logic [CHAN_W-1:0]        v_chan   [VOICES];
  logic [VEL_W-1:0]         v_vol    [VOICES];
  logic [STEP_W-1:0]        v_inc    [VOICES];
  logic [STEP_W-1:0]        v_phase  [VOICES];
  logic signed [WAVE_W-1:0] wave_mem [TBL_LEN];
  logic [STEP_W-1:0]        step_mem [STEP_DEPTH];

  logic [DAC_W-1:0] exp_dac_q [$];   // samples still owed by the block

  int  err_count;
  int  n_in;
  int  n_out;
  int  n_ticks;
  int  n_note_on;
  int  n_dropped;
  int  n_clamp_hi;
  int  n_clamp_lo;
  int  stall_cnt;
  bit  no_idle;
  logic [DAC_W-1:0] want_dac;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Free the lowest-index active voice holding this key; no match is a no-op.
  function automatic void voice_release(input logic [KEY_W-1:0] key);
    for (int v = 0; v < VOICES; v++) begin
      if (v_active[v] && v_note[v] == key) begin
        v_active[v] = 1'b0;
        v_chan[v]   = '0;
        return;
      end
    end
  endfunction

  // Grab the lowest free voice; returns 0 when the pool is full (note dropped).
  function automatic bit voice_claim(input synth_cmd_t c);
    for (int v = 0; v < VOICES; v++) begin
      if (!v_active[v]) begin
        v_note[v]   = c.key;
        v_inc[v]    = step_mem[c.key];
        v_phase[v]  = '0;
        v_vol[v]    = c.vel;
        v_chan[v]   = c.chan;
        v_active[v] = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance every active voice and mix one DAC sample.
  function automatic logic [DAC_W-1:0] mix_tick();
    logic [STEP_W:0]   ph;
    logic [WIDX_W-1:0] idx;
    int                mix;
    mix = 0;
    for (int v = 0; v < VOICES; v++) begin
      if (v_active[v]) begin
        ph = {1'b0, v_phase[v]} + {1'b0, v_inc[v]};
        if (ph >= SPAN) ph = ph - (STEP_W + 1)'(SPAN);  // single wrap, steps stay below span
        v_phase[v] = ph[STEP_W-1:0];
        idx = v_phase[v][STEP_W-1:FRAC_W];
        mix = mix + ((int'(wave_mem[idx]) * int'(v_vol[v])) >>> VOL_SHIFT);
      end
    end
    mix = (mix >>> MIX_SHIFT) + DAC_MID;
    if (mix > DAC_MAX) begin
      n_clamp_hi++;
      return DAC_W'(DAC_MAX);
    end
    if (mix < 0) begin
      n_clamp_lo++;
      return '0;
    end
    return DAC_W'(mix);
  endfunction

  function automatic void apply_cmd(input synth_cmd_t c);
    n_in++;
    case (c.opc)
      OP_TICK: begin
        n_ticks++;
        exp_dac_q.push_back(mix_tick());
      end
      OP_NOTE_ON: begin
        if (c.vel == 0) begin
          voice_release(c.key);    // zero velocity means note off
        end else begin
          n_note_on++;
          if (!voice_claim(c)) n_dropped++;
        end
      end
      OP_NOTE_OFF:  voice_release(c.key);
      OP_LOAD_WAVE: wave_mem[c.widx] = c.wval;
      OP_LOAD_STEP: step_mem[c.key] = c.step;
      default: ;                   // unknown opcodes do nothing
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic synth_cmd_t rand_fields();
    synth_cmd_t c;
    c.opc  = OPC_W'($urandom_range(7));
    c.key  = KEY_W'($urandom_range(127));
    c.vel  = VEL_W'($urandom_range(127));
    c.chan = CHAN_W'($urandom_range(15));
    c.widx = WIDX_W'($urandom_range(TBL_LEN - 1));
    c.wval = WAVE_W'($urandom_range(65535));
    c.step = STEP_W'($urandom());
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back item never toggles it.
  task automatic send_cmd(input synth_cmd_t c);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.opcode     <= c.opc;
    in_ch.note_key   <= c.key;
    in_ch.velocity   <= c.vel;
    in_ch.channel    <= c.chan;
    in_ch.wave_index <= c.widx;
    in_ch.wave_value <= c.wval;
    in_ch.step_value <= c.step;
    in_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_cmd(c);
    @(negedge clk);
  endtask

  // Sender holds off until every owed sample has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (exp_dac_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_op(input logic [OPC_W-1:0] opc, input logic [KEY_W-1:0] key,
                         input logic [VEL_W-1:0] vel);
    synth_cmd_t c;
    c = rand_fields();
    c.opc = opc;
    c.key = key;
    c.vel = vel;
    send_cmd(c);
  endtask

  task automatic send_wave(input int idx, input logic signed [WAVE_W-1:0] val);
    synth_cmd_t c;
    c = rand_fields();
    c.opc  = OP_LOAD_WAVE;
    c.widx = WIDX_W'(idx);
    c.wval = val;
    send_cmd(c);
  endtask

  task automatic send_step(input int key, input logic [STEP_W-1:0] val);
    synth_cmd_t c;
    c = rand_fields();
    c.opc  = OP_LOAD_STEP;
    c.key  = KEY_W'(key);
    c.step = val;
    send_cmd(c);
  endtask

  // Result side backpressure
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (exp_dac_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected dac_sample: expected none, actual %0d",
                 $time, out_ch.dac_sample);
      end else begin
        want_dac = exp_dac_q.pop_front();
        if (out_ch.dac_sample !== want_dac) begin
          err_count++;
          $display("%0t: dac_sample mismatch: expected %0d, actual %0d",
                   $time, want_dac, out_ch.dac_sample);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d samples outstanding",
                 $time, STALL_LIMIT, exp_dac_q.size());
        $display("** wavetable_voice_mixer: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Nothing loaded yet: only commands that read no table.
  task automatic test_empty_pool();
    send_op(OP_TICK, 0, 0);               // silence mixes to mid scale
    send_op(OP_NOTE_OFF, 3, 0);           // no voice to free
    send_op(3'd5, 127, 127);              // unknown opcodes
    send_op(3'd6, 0, 0);
    send_op(3'd7, 64, 1);
    send_op(OP_TICK, 127, 127);
  endtask

  // Every table entry written once, with the field extremes in the mix.
  task automatic fill_tables();
    for (int k = 0; k < STEP_DEPTH; k++) begin
      case (k % 4)
        0:       send_step(k, STEP_W'($urandom()));
        1:       send_step(k, STEP_W'($urandom_range(1 << 20)));
        2:       send_step(k, {STEP_W{1'b1}});    // largest step, wraps on every tick after the first
        default: send_step(k, STEP_W'($urandom_range(1 << 16, 1 << 18)));
      endcase
    end
    for (int i = 0; i < TBL_LEN; i++) begin
      case (i % 8)
        0:       send_wave(i, 16'sh7fff);
        1:       send_wave(i, -16'sh8000);
        default: send_wave(i, WAVE_W'($urandom_range(65535)));
      endcase
    end
  endtask

  // Fill the pool with loud zero-step voices parked on entry 0, overflow the
  // pool, drive the mix into both clamps, then release voices.
  task automatic test_full_pool();
    synth_cmd_t c;
    send_wave(0, 16'sh7fff);
    send_step(5, '0);
    for (int v = 0; v < VOICES; v++) begin
      c = rand_fields();
      c.opc  = OP_NOTE_ON;
      c.key  = 7'd5;
      c.vel  = 7'd127;
      c.chan = CHAN_W'(v);
      send_cmd(c);
    end
    c.key  = 7'd127;
    c.chan = 4'd15;
    send_cmd(c);                          // pool full: dropped
    send_op(OP_TICK, 0, 0);               // clamps high
    send_wave(0, -16'sh8000);
    send_op(OP_TICK, 0, 0);               // clamps low
    send_op(OP_NOTE_OFF, 5, 0);           // frees voice 0
    send_op(OP_NOTE_ON, 5, 0);            // zero velocity frees voice 1
    send_op(OP_NOTE_OFF, 99, 0);          // no match
    send_op(OP_TICK, 0, 0);
    wait_drained();
    for (int v = 2; v < VOICES; v++) send_op(OP_NOTE_OFF, 5, 0);
    send_wave(0, WAVE_W'($urandom_range(65535)));
  endtask

  // Mostly legal note traffic: a small key pool makes repeats and matching
  // note-offs common; ticks dominate so the phases run deep.
  task automatic test_random();
    synth_cmd_t c;
    int         r;
    int         start;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      no_idle = (i >= 40 && i < 100);
      if (i == 110) wait_drained();
      c = rand_fields();
      r = $urandom_range(99);
      if (r < 40) begin
        c.opc = OP_TICK;
      end else if (r < 62) begin
        c.opc = OP_NOTE_ON;
        if ($urandom_range(1)) c.key = KEY_W'(60 + $urandom_range(7));
        r = $urandom_range(99);
        if (r < 6)       c.vel = '0;
        else if (r < 16) c.vel = 7'd127;
        else             c.vel = VEL_W'($urandom_range(1, 127));
      end else if (r < 80) begin
        c.opc = OP_NOTE_OFF;
        if ($urandom_range(99) < 70) begin
          start = $urandom_range(VOICES - 1);
          for (int k = 0; k < VOICES; k++) begin
            if (v_active[(start + k) % VOICES]) begin
              c.key = v_note[(start + k) % VOICES];
              break;
            end
          end
        end
      end else if (r < 90) begin
        c.opc = OP_LOAD_WAVE;
      end else if (r < 96) begin
        c.opc = OP_LOAD_STEP;
        if ($urandom_range(1)) c.step = STEP_W'($urandom_range(1 << 20));
      end else begin
        c.opc = OPC_W'(5 + $urandom_range(2));
      end
      send_cmd(c);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    no_idle          = 1'b0;
    err_count        = 0;
    n_in             = 0;
    n_out            = 0;
    n_ticks          = 0;
    n_note_on        = 0;
    n_dropped        = 0;
    n_clamp_hi       = 0;
    n_clamp_lo       = 0;
    stall_cnt        = 0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = '0;
    in_ch.note_key   = '0;
    in_ch.velocity   = '0;
    in_ch.channel    = '0;
    in_ch.wave_index = '0;
    in_ch.wave_value = '0;
    in_ch.step_value = '0;
    out_ch.ready     = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      v_active[v] = 1'b0;
      v_note[v]   = '0;
      v_chan[v]   = '0;
      v_vol[v]    = '0;
      v_inc[v]    = '0;
      v_phase[v]  = '0;
    end
    for (int i = 0; i < TBL_LEN; i++) wave_mem[i] = '0;
    for (int k = 0; k < STEP_DEPTH; k++) step_mem[k] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_pool();
    fill_tables();
    test_full_pool();
    wait_drained();
    test_random();
    wait_drained();

    // give the block time to show any stray sample
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_dac_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected samples never arrived", $time, exp_dac_q.size());
    end

    $display("Run covered %0d input transactions and %0d samples: %0d ticks, %0d note-ons",
             n_in, n_out, n_ticks, n_note_on);
    $display("  %0d notes dropped on a full pool, %0d high and %0d low clamps, %0d errors",
             n_dropped, n_clamp_hi, n_clamp_lo, err_count);
    if (err_count == 0) begin
      $display("** wavetable_voice_mixer: PASSED **");
    end else begin
      $display("** wavetable_voice_mixer: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wvm_pkg.sv
rtl/wvm_ifs.sv
rtl/wvm_phase_wrap.sv
rtl/wavetable_voice_mixer.sv
verif/tb_top.sv
